/* rtl/ats_pkg.sv */
// shared types, constants and the cordic angle table for the tilt block
// no dependencies
package ats_pkg;

    localparam int CordicStepsDef = 16;
    localparam int FracBitsDef    = 16;
    localparam int WorkFrac       = 23;
    localparam int TableLen       = 24;
    localparam int WorkW          = 36;   // signed working width for root and cordic
    localparam int SqW            = 64;
    localparam int RootW          = 32;
    localparam int AngW           = 33;
    localparam logic [16:0] WeightOne   = 17'd65536;
    localparam logic [16:0] WeightReset = 17'd6554;

    localparam logic [0:0] RegWeight = 1'b0;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_FILT   = 7'b0000010,
        ST_LOAD   = 7'b0000100,
        ST_SQRT   = 7'b0001000,
        ST_CORDIC = 7'b0010000,
        ST_DONE   = 7'b0100000,
        ST_OUT    = 7'b1000000
    } ats_state_t;

    typedef struct packed {
        logic filt;
        logic load;     // load root operands, sel picks pitch or roll
        logic sel;
        logic sqrt_step;
        logic cordic_init;
        logic cordic_step;
        logic store;
    } ats_cmd_t;

    typedef struct packed {
        logic sqrt_last;
        logic cordic_last;
    } ats_stat_t;

    function automatic logic [AngW-1:0] atan_entry(input logic [4:0] i);
        logic [AngW-1:0] v;
        begin
            case (i)
                5'd0: v = 33'd294912000;
                5'd1: v = 33'd174096719;
                5'd2: v = 33'd91987925;
                5'd3: v = 33'd46694507;
                5'd4: v = 33'd23437865;
                5'd5: v = 33'd11730358;
                5'd6: v = 33'd5866610;
                5'd7: v = 33'd2933484;
                5'd8: v = 33'd1466764;
                5'd9: v = 33'd733385;
                5'd10: v = 33'd366693;
                5'd11: v = 33'd183346;
                5'd12: v = 33'd91673;
                5'd13: v = 33'd45837;
                5'd14: v = 33'd22918;
                5'd15: v = 33'd11459;
                5'd16: v = 33'd5730;
                5'd17: v = 33'd2865;
                5'd18: v = 33'd1432;
                5'd19: v = 33'd716;
                5'd20: v = 33'd358;
                5'd21: v = 33'd179;
                5'd22: v = 33'd90;
                5'd23: v = 33'd45;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

/* rtl/ats_ctrl.sv */
// sequencer for the tilt block: filter, then root and cordic for pitch and roll
// depends on ats_pkg
module ats_ctrl import ats_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  ats_stat_t  stat,
    output ats_cmd_t   cmd
);

    ats_state_t state_reg, state_next;
    logic       sel_reg, sel_next;
    logic       ovalid_reg, ovalid_next;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = ovalid_reg;

    always_comb
    begin
        state_next  = state_reg;
        sel_next    = sel_reg;
        ovalid_next = ovalid_reg;
        cmd         = '0;
        cmd.sel     = sel_reg;
        if (ovalid_reg && !out_stall)
            ovalid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_FILT;
            end
            ST_FILT:
            begin
                cmd.filt   = 1'b1;
                sel_next   = 1'b0;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (stat.sqrt_last)
                    state_next = ST_CORDIC;
            end
            ST_CORDIC:
            begin
                cmd.cordic_init = 1'b1;
                state_next      = ST_DONE;
            end
            ST_DONE:
            begin
                cmd.cordic_step = 1'b1;
                if (stat.cordic_last)
                begin
                    if (sel_reg)
                        state_next = ST_OUT;
                    else
                    begin
                        sel_next   = 1'b1;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_OUT:
            begin
                // result register must be free before it is overwritten
                if (!ovalid_reg || !out_stall)
                begin
                    cmd.store   = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            sel_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sel_reg    <= sel_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

/* rtl/ats_datapath.sv */
// smoothing filters, bit-serial integer root and iterated cordic
// depends on ats_pkg
module ats_datapath import ats_pkg::*; #(
    parameter int CORDIC_STEPS = CordicStepsDef,
    parameter int FRAC_BITS    = FracBitsDef
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_take,
    input  logic signed [7:0] accel_x,
    input  logic signed [7:0] accel_y,
    input  logic signed [7:0] accel_z,
    input  logic [16:0]       weight,
    input  ats_cmd_t          cmd,
    output ats_stat_t         stat,
    output logic signed [14:0] pitch_angle,
    output logic signed [14:0] roll_angle
);

    localparam int SW     = 8 + FRAC_BITS;
    localparam int AccW   = SW + 19;
    localparam int NSteps = (CORDIC_STEPS > TableLen) ? TableLen : CORDIC_STEPS;

    logic signed [7:0]  samp_reg [3];
    logic signed [SW-1:0] sm_reg [3];
    logic signed [17:0] w_c;
    logic signed [17:0] wc_c;

    // weight and its complement, both non-negative
    assign w_c  = (weight > WeightOne) ? $signed({1'b0, WeightOne}) : $signed({1'b0, weight});
    assign wc_c = $signed({1'b0, WeightOne}) - w_c;

    // filter: sample captured at the accept, sum and round in the next cycle
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            samp_reg[0] <= accel_x;
            samp_reg[1] <= accel_y;
            samp_reg[2] <= accel_z;
        end
    end

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        logic signed [25:0]     pn;
        logic signed [SW+17:0]  po;
        logic signed [AccW-1:0] sum;
        assign pn  = samp_reg[a] * w_c;
        assign po  = sm_reg[a] * wc_c;
        assign sum = (AccW'(pn) <<< FRAC_BITS) + AccW'(po) + AccW'(32768);
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sm_reg[a] <= '0;
            else if (cmd.filt)
                sm_reg[a] <= SW'(sum >>> 16);
        end
    end

    function automatic logic signed [WorkW-1:0] to_work(input logic signed [SW-1:0] v);
        begin
            if (FRAC_BITS <= WorkFrac)
                return WorkW'(v) <<< (WorkFrac - FRAC_BITS);
            else
                return WorkW'(v >>> (FRAC_BITS - WorkFrac));
        end
    endfunction

    // root operand selection
    logic signed [WorkW-1:0] wn, wa, wb;
    always_comb
    begin
        wn = cmd.sel ? to_work(sm_reg[1]) : to_work(sm_reg[0]);
        wa = cmd.sel ? to_work(sm_reg[0]) : to_work(sm_reg[1]);
        wb = to_work(sm_reg[2]);
    end

    logic [SqW-1:0]   rem_reg;
    logic [SqW-1:0]   root_reg;
    logic [5:0]       bit_reg;   // bit position / 2
    logic signed [WorkW-1:0] num_reg;
    logic [SqW-1:0]   sq_a, sq_b;
    logic [30:0]      ma, mb;
    logic [61:0]      pa, pb;

    // operands are at most 2^30 in magnitude, so squares fit 62 bits
    assign ma   = wa[WorkW-1] ? 31'(-wa) : 31'(wa);
    assign mb   = wb[WorkW-1] ? 31'(-wb) : 31'(wb);
    assign pa   = ma * ma;
    assign pb   = mb * mb;
    assign sq_a = SqW'(pa);
    assign sq_b = SqW'(pb);

    logic [SqW-1:0] bitv, trial;
    assign bitv  = SqW'(1) << {bit_reg, 1'b0};
    assign trial = root_reg + bitv;
    assign stat.sqrt_last = (bit_reg == 6'd0);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rem_reg  <= sq_a + sq_b;
            root_reg <= '0;
            bit_reg  <= 6'd31;
            num_reg  <= wn;
        end
        else if (cmd.sqrt_step)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg  <= rem_reg - trial;
                root_reg <= (root_reg >> 1) + bitv;
            end
            else
                root_reg <= root_reg >> 1;
            if (bit_reg != 6'd0)
                bit_reg <= bit_reg - 6'd1;
        end
    end

    // cordic vectoring
    logic signed [WorkW+1:0] cx_reg, cy_reg;
    logic signed [AngW+1:0]  cz_reg;
    logic [4:0]              it_reg;
    logic                    zero_reg;
    logic signed [WorkW+1:0] xs, ys;
    logic signed [AngW+1:0]  tab;

    assign xs  = cx_reg >>> it_reg;
    assign ys  = cy_reg >>> it_reg;
    assign tab = (AngW+2)'(atan_entry(it_reg));
    assign stat.cordic_last = (it_reg == 5'(NSteps - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.cordic_init)
        begin
            cx_reg   <= (WorkW+2)'(root_reg[RootW-1:0]);
            cy_reg   <= (WorkW+2)'(num_reg);
            cz_reg   <= '0;
            it_reg   <= '0;
            zero_reg <= (root_reg == '0) && (num_reg == '0);
        end
        else if (cmd.cordic_step)
        begin
            if (cy_reg >= 0)
            begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + tab;
            end
            else
            begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - tab;
            end
            it_reg <= it_reg + 5'd1;
        end
    end

    // final angle: z after the last step is formed combinationally
    logic signed [AngW+1:0] zf, zr;
    logic signed [14:0]     ang;
    always_comb
    begin
        zf = (cy_reg >= 0) ? cz_reg + tab : cz_reg - tab;
        zr = (zf + (AngW+2)'(32768)) >>> 16;
        if (zero_reg)
            ang = '0;
        else if (zr > (AngW+2)'(9000))
            ang = 15'sd9000;
        else if (zr < -(AngW+2)'(9000))
            ang = -15'sd9000;
        else
            ang = 15'(zr);
    end

    logic signed [14:0] pitch_hold_reg, pitch_reg, roll_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.cordic_step && stat.cordic_last)
        begin
            if (cmd.sel)
                roll_reg <= ang;
            else
                pitch_hold_reg <= ang;
        end
        if (cmd.store)
            pitch_reg <= pitch_hold_reg;
    end

    logic signed [14:0] roll_out_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.store)
            roll_out_reg <= roll_reg;
    end

    assign pitch_angle = pitch_reg;
    assign roll_angle  = roll_out_reg;

endmodule

/* rtl/accel_tilt_smoothing.sv */
// tilt block top level: apb register, sequencer and datapath
// depends on ats_pkg, ats_ctrl, ats_datapath
//
// usage:
//   input channel carries accel_x/y/z (signed 1/256 g) with in_valid/in_stall.
//   output channel carries pitch_angle and roll_angle in hundredths of a degree
//   with out_valid/out_stall; one result item per input item.
//   register 0 at byte address 0 holds smoothing_weight (16 fraction bits).
// timing:
//   one item at a time; each item runs the filter, then for pitch and then
//   for roll the bit-serial root (32 steps) and the cordic iterations (steps
//   above 24 run as 24). the result becomes valid once both angles are done
//   and the output register is free.
//   the input is stalled while an item is being worked on.
// reset:
//   smoothed axes clear to zero, weight returns to 6554, no result pending.
// stall:
//   a finished result waits in the output register while out_stall is high;
//   the next item may be accepted and worked on, and it waits before storing.
module accel_tilt_smoothing import ats_pkg::*; #(
    parameter int CORDIC_STEPS = CordicStepsDef,
    parameter int FRAC_BITS    = FracBitsDef
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic signed [7:0] accel_x,
    input  logic signed [7:0] accel_y,
    input  logic signed [7:0] accel_z,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [14:0] pitch_angle,
    output logic signed [14:0] roll_angle
);

    logic [16:0] weight_reg;
    ats_cmd_t    cmd;
    ats_stat_t   stat;

    assign pready = 1'b1;
    assign prdata = (paddr == RegWeight) ? {15'd0, weight_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            weight_reg <= WeightReset;
        else if (psel && penable && pwrite && paddr == RegWeight)
            weight_reg <= pwdata[16:0];
    end

    ats_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    ats_datapath #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_take     (in_valid && !in_stall),
        .accel_x     (accel_x),
        .accel_y     (accel_y),
        .accel_z     (accel_z),
        .weight      (weight_reg),
        .cmd         (cmd),
        .stat        (stat),
        .pitch_angle (pitch_angle),
        .roll_angle  (roll_angle)
    );

endmodule

/* tb/accel_tilt_smoothing_tb.sv */
// testbench for accel_tilt_smoothing: random and directed readings, apb weight writes
// depends on ats_pkg and the accel_tilt_smoothing rtl
`timescale 1ns / 100ps

class tilt_scoreboard;
    typedef struct {
        logic signed [14:0] pitch;
        logic signed [14:0] roll;
    } angles_t;

    angles_t    pending_angles[$];
    longint     sm_x, sm_y, sm_z;
    logic [16:0] weight;
    int         fail_count;

    function void clear_state();
        sm_x = 0;
        sm_y = 0;
        sm_z = 0;
        weight = ats_pkg::WeightReset;
    endfunction

    function longint smooth(longint old, longint sample, longint w);
        longint acc;
        acc = w * (sample <<< 16) + (64'sd65536 - w) * old;
        return (acc + 32768) >>> 16;
    endfunction

    function longint unsigned floor_root(longint unsigned n);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // angle of (sqrt(a*a+b*b), num) in hundredths of a degree
    function longint tilt_angle(longint num, longint a, longint b);
        longint wa, wb, x, y, z, nx;
        longint unsigned sq;
        wa = a <<< 7;
        wb = b <<< 7;
        sq = longint'(wa * wa) + longint'(wb * wb);
        x = longint'(floor_root(sq));
        y = num <<< 7;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        for (int i = 0; i < 16; i++)
        begin
            if (y >= 0)
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + longint'(ats_pkg::atan_entry(i[4:0]));
            end
            else
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - longint'(ats_pkg::atan_entry(i[4:0]));
            end
            x = nx;
        end
        z = (z + 32768) >>> 16;
        if (z > 9000)
            z = 9000;
        if (z < -9000)
            z = -9000;
        return z;
    endfunction

    function void note_reading(logic signed [7:0] ax, logic signed [7:0] ay,
                               logic signed [7:0] az);
        longint w;
        angles_t e;
        w = (weight > ats_pkg::WeightOne) ? 65536 : longint'(weight);
        sm_x = smooth(sm_x, longint'(ax), w);
        sm_y = smooth(sm_y, longint'(ay), w);
        sm_z = smooth(sm_z, longint'(az), w);
        e.pitch = 15'(tilt_angle(sm_x, sm_y, sm_z));
        e.roll = 15'(tilt_angle(sm_y, sm_x, sm_z));
        pending_angles.push_back(e);
    endfunction

    function void check_angles(logic signed [14:0] pitch, logic signed [14:0] roll);
        angles_t e;
        if (pending_angles.size() == 0)
        begin
            $display("%0t: unexpected item pitch=%0d roll=%0d", $time, pitch, roll);
            fail_count++;
            return;
        end
        e = pending_angles.pop_front();
        if (pitch !== e.pitch)
        begin
            $display("%0t: pitch_angle expected %0d actual %0d", $time, e.pitch, pitch);
            fail_count++;
        end
        if (roll !== e.roll)
        begin
            $display("%0t: roll_angle expected %0d actual %0d", $time, e.roll, roll);
            fail_count++;
        end
    endfunction
endclass

module accel_tilt_smoothing_tb;
    import ats_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [0:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [7:0] accel_x = '0, accel_y = '0, accel_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [14:0] pitch_angle, roll_angle;

    tilt_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_request = 1'b0;
    int quiet_cycles = 0;

    accel_tilt_smoothing dut (.*);

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_reading(accel_x, accel_y, accel_z);
            if (out_valid && !out_stall)
                sb.check_angles(pitch_angle, roll_angle);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > 6000)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // receiver; a hold request keeps the output stalled so the block backs up
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                repeat (1500)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic write_weight(logic [16:0] w);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= RegWeight;
        pwdata <= {15'd0, w};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.weight = w;
    endtask

    task automatic send_reading(logic signed [7:0] ax, logic signed [7:0] ay,
                                logic signed [7:0] az);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        accel_x <= ax;
        accel_y <= ay;
        accel_z <= az;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_angles.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    function automatic logic signed [7:0] pick_sample();
        case ($urandom_range(9))
            0: return 8'sh7f;
            1: return 8'sh80;
            2: return 8'sh00;
            3: return 8'($urandom_range(4) - 2);
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    logic [16:0] phase_weights[6] = '{17'd6554, 17'd65536, 17'd131071, 17'd1,
                                      17'd40000, 17'd65537};

    initial
    begin
        sb.clear_state();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: default weight, then a pass-through weight for the extremes
        send_reading(8'sd127, -8'sd128, 8'sd64);
        send_reading(8'sd0, 8'sd0, 8'sd0);
        drain();
        write_weight(WeightOne);
        send_reading(8'sd0, 8'sd0, 8'sd0);
        send_reading(8'sd127, 8'sd0, 8'sd0);
        send_reading(-8'sd128, 8'sd0, 8'sd0);
        send_reading(8'sd0, 8'sd127, 8'sd0);
        send_reading(8'sd0, -8'sd128, 8'sd0);
        send_reading(8'sd0, 8'sd0, 8'sd127);
        send_reading(8'sd0, 8'sd0, -8'sd128);
        send_reading(8'sd127, 8'sd127, 8'sd127);
        send_reading(-8'sd128, -8'sd128, -8'sd128);
        send_reading(8'sd127, -8'sd128, 8'sd0);
        send_reading(8'sd1, 8'sd0, 8'sd0);
        send_reading(-8'sd1, -8'sd1, -8'sd1);
        send_reading(8'sd85, -8'sd86, 8'sd1);
        drain();
        // weight above one behaves as one; zero weight freezes the filter
        write_weight(17'h1ffff);
        send_reading(8'sd100, -8'sd20, 8'sd3);
        drain();
        write_weight(17'd0);
        send_reading(8'sd127, 8'sd127, 8'sd127);
        send_reading(-8'sd128, 8'sd5, 8'sd0);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph < 2)
            begin
                send_idle_pct = 34;
                recv_stall_pct = 52;
            end
            else if (ph < 4)
            begin
                send_idle_pct = 52;
                recv_stall_pct = 34;
            end
            else
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            write_weight((ph == 4) ? 17'($urandom_range(65536)) : phase_weights[ph]);
            for (int n = 0; n < 280; n++)
            begin
                if (ph == 1 && n == 40)
                    hold_request = 1'b1;
                send_reading(pick_sample(), pick_sample(), pick_sample());
            end
            drain();
        end

        if (sb.fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

/* files.f */
rtl/ats_pkg.sv
rtl/ats_ctrl.sv
rtl/ats_datapath.sv
rtl/accel_tilt_smoothing.sv
tb/accel_tilt_smoothing_tb.sv
